/* hdl/tsee_pkg.sv */
// ----------------------------------------------------------------------------
// tsee_pkg
// Shared types, codes and sizes of the typed stack expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsee_pkg;

  // Stack geometry and word size
  localparam int STACK_DEPTH = 256;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Fixed field widths of the stream beats
  localparam int CMD_W   = 5;
  localparam int TAG_W   = 2;
  localparam int CVAL_W  = 32;
  localparam int STAT_W  = 3;
  localparam int RETV_W  = 32;
  localparam int DEPTH_W = 9;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 48;

  // Instruction codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LDC = 5'd0,
    CMD_LBT = 5'd1,
    CMD_LBF = 5'd2,
    CMD_LN0 = 5'd3,
    CMD_LN1 = 5'd4,
    CMD_LM1 = 5'd5,
    CMD_LZ0 = 5'd6,
    CMD_LZ1 = 5'd7,
    CMD_NEG = 5'd8,
    CMD_ADD = 5'd9,
    CMD_SUB = 5'd10,
    CMD_MUL = 5'd11,
    CMD_CEQ = 5'd12,
    CMD_CNE = 5'd13,
    CMD_NOT = 5'd14,
    CMD_IOR = 5'd15,
    CMD_AND = 5'd16,
    CMD_RET = 5'd17
  } cmd_t;

  // Value type tags
  typedef enum logic [TAG_W-1:0] {
    TAG_BOOL = 2'd0,
    TAG_CHAR = 2'd1,
    TAG_NAT  = 2'd2,
    TAG_INT  = 2'd3
  } tag_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK  = 3'd0,
    ST_RET = 3'd1,
    ST_ERR = 3'd2,
    ST_OVF = 3'd3,
    ST_UNF = 3'd4,
    ST_UNK = 3'd5
  } status_t;

  // Effect of one instruction on the stack
  typedef enum logic [2:0] {
    ACT_NONE,      // stack unchanged
    ACT_PUSH,      // push one entry
    ACT_REPL,      // replace the top entry
    ACT_POP1,      // drop the top entry
    ACT_POP2PUSH,  // drop two entries, push the result
    ACT_POP2       // drop two entries
  } act_t;

  // One stack entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] value;
  } entry_t;

  // Decision of the execute unit for one instruction
  typedef struct packed {
    status_t status;
    act_t    act;
    entry_t  push;
    entry_t  ret;
  } exec_t;

endpackage

`default_nettype wire

/* hdl/tsee_stack_ram.sv */
// ----------------------------------------------------------------------------
// tsee_stack_ram
// Stack storage: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsee_stack_ram
  import tsee_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr0,
  input  wire logic [ADDR_W-1:0] rd_addr1,
  output entry_t                 rd_data0,
  output entry_t                 rd_data1
);

  entry_t mem [STACK_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered read data
  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

`default_nettype wire

/* hdl/tsee_exec.sv */
// ----------------------------------------------------------------------------
// tsee_exec
// Instruction decode and execute: type rules, arithmetic and stack effect.
// ----------------------------------------------------------------------------
`default_nettype none

module tsee_exec
  import tsee_pkg::*;
(
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [TAG_W-1:0]  const_tag,
  input  wire logic [CVAL_W-1:0] const_value,
  input  wire logic [SP_W-1:0]   sp,
  input  wire entry_t            top0,   // entry at sp-1, left operand
  input  wire entry_t            top1,   // entry at sp-2, right operand
  output exec_t                  res
);

  logic              full;
  logic              lt_true;
  logic              rt_true;
  logic              eq;
  logic [WORD_W-1:0] lv;
  logic [WORD_W-1:0] rv;
  tag_t              lt;

  assign lv      = top0.value;
  assign rv      = top1.value;
  assign lt      = tag_t'(top0.tag);
  assign full    = (sp == SP_W'(STACK_DEPTH));
  assign lt_true = |lv;
  assign rt_true = |rv;
  assign eq      = (lt == TAG_BOOL) ? (lt_true == rt_true) : (lv == rv);

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    res.act    = ACT_NONE;

    unique case (command)
      // Constant loads
      CMD_LDC, CMD_LBT, CMD_LBF, CMD_LN0, CMD_LN1, CMD_LM1, CMD_LZ0, CMD_LZ1: begin
        case (command)
          CMD_LDC: res.push = '{tag: const_tag, value: WORD_W'(const_value)};
          CMD_LBT: res.push = '{tag: TAG_BOOL, value: WORD_W'(1)};
          CMD_LBF: res.push = '{tag: TAG_BOOL, value: '0};
          CMD_LN0: res.push = '{tag: TAG_NAT, value: '0};
          CMD_LN1: res.push = '{tag: TAG_NAT, value: WORD_W'(1)};
          CMD_LM1: res.push = '{tag: TAG_INT, value: '1};
          CMD_LZ0: res.push = '{tag: TAG_INT, value: '0};
          default: res.push = '{tag: TAG_INT, value: WORD_W'(1)};
        endcase
        if (full) begin
          res.status = ST_OVF;
          res.push   = '0;
        end else begin
          res.act = ACT_PUSH;
        end
      end

      // One-operand instructions
      CMD_NEG, CMD_NOT, CMD_RET: begin
        if (sp == '0) begin
          res.status = ST_UNF;
        end else if (command == CMD_RET) begin
          res.status = ST_RET;
          res.act    = ACT_POP1;
          res.ret    = top0;
        end else if (command == CMD_NEG) begin
          if (lt == TAG_INT) begin
            res.act  = ACT_REPL;
            res.push = '{tag: TAG_INT, value: WORD_W'(0) - lv};
          end else begin
            res.status = ST_ERR;
            res.act    = ACT_POP1;
          end
        end else if (lt == TAG_BOOL) begin
          res.act  = ACT_REPL;
          res.push = '{tag: TAG_BOOL, value: WORD_W'(!lt_true)};
        end else if (lt == TAG_NAT) begin
          res.act  = ACT_REPL;
          res.push = '{tag: TAG_NAT, value: ~lv};
        end else begin
          res.status = ST_ERR;
          res.act    = ACT_POP1;
        end
      end

      // Two-operand instructions
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_CEQ, CMD_CNE, CMD_IOR, CMD_AND: begin
        if (sp < SP_W'(2)) begin
          res.status = ST_UNF;
        end else if (top0.tag != top1.tag) begin
          // Mismatched operands are dropped; only IOR flags it
          res.act    = ACT_POP2;
          res.status = (command == CMD_IOR) ? ST_ERR : ST_OK;
        end else begin
          res.act = ACT_POP2PUSH;
          case (command)
            CMD_ADD: begin
              res.push = '{tag: lt, value: lv + rv};
              if (lt != TAG_NAT && lt != TAG_INT) res.act = ACT_POP2;
            end
            CMD_SUB: begin
              res.push = '{tag: lt, value: lv - rv};
              if (lt != TAG_INT) res.act = ACT_POP2;
            end
            CMD_MUL: begin
              res.push = '{tag: lt, value: lv * rv};
              if (lt != TAG_NAT && lt != TAG_INT) res.act = ACT_POP2;
            end
            CMD_CEQ: res.push = '{tag: TAG_BOOL, value: WORD_W'(eq)};
            CMD_CNE: res.push = '{tag: TAG_BOOL, value: WORD_W'(!eq)};
            CMD_IOR: begin
              if (lt == TAG_BOOL)
                res.push = '{tag: TAG_BOOL, value: WORD_W'(lt_true | rt_true)};
              else
                res.push = '{tag: TAG_NAT, value: lv | rv};
              if (lt != TAG_BOOL && lt != TAG_NAT) res.act = ACT_POP2;
            end
            default: begin
              if (lt == TAG_BOOL)
                res.push = '{tag: TAG_BOOL, value: WORD_W'(lt_true & rt_true)};
              else
                res.push = '{tag: TAG_NAT, value: lv & rv};
              if (lt != TAG_BOOL && lt != TAG_NAT) res.act = ACT_POP2;
            end
          endcase
          // Unsupported type: operands dropped, nothing pushed
          if (res.act == ACT_POP2) begin
            res.status = ST_ERR;
            res.push   = '0;
          end
        end
      end

      default: res.status = ST_UNK;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/typed_stack_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// typed_stack_expression_evaluator
// Bytecode stack machine on tagged values, one instruction per input beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_tvalid / in_tready   | command, const_tag, const_value
//  out_    | output    | out_tvalid / out_tready | status, ret_tag, ret_value,
//          |           |                         | stack_depth
//
//  One instruction per cycle while in_tready is high, one result beat per
//  instruction. The stack RAM has registered read data; the top two entries
//  live in registers and the two entries below them are read ahead every
//  cycle, so no instruction waits on the RAM. Reset clears the stack pointer
//  and the output valid flag, not the RAM. in_tready is high whenever the
//  output register is empty or is being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_stack_expression_evaluator
  import tsee_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // command[4:0], const_tag[6:5],
                                             // const_value[38:7], zero[39]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata   // status[2:0], ret_tag[4:3],
                                             // ret_value[36:5],
                                             // stack_depth[45:37], zero[47:46]
);

  logic              in_fire;
  logic [SP_W-1:0]   sp_r;
  logic [SP_W-1:0]   sp_nxt;
  entry_t            top0_r;
  entry_t            top0_nxt;
  entry_t            top1_r;
  entry_t            top1_nxt;
  entry_t            below0;   // entry at sp-3
  entry_t            below1;   // entry at sp-4
  exec_t             ex;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr0;
  logic [ADDR_W-1:0] rd_addr1;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [OUT_DW-1:0] out_data_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Execute the instruction against the cached top entries
  tsee_exec u_exec (
    .command     (in_tdata[4:0]),
    .const_tag   (in_tdata[6:5]),
    .const_value (in_tdata[38:7]),
    .sp          (sp_r),
    .top0        (top0_r),
    .top1        (top1_r),
    .res         (ex)
  );

  // Advance stack pointer and cached top entries
  always_comb begin
    sp_nxt   = sp_r;
    top0_nxt = top0_r;
    top1_nxt = top1_r;
    if (in_fire) begin
      case (ex.act)
        ACT_PUSH: begin
          sp_nxt   = sp_r + SP_W'(1);
          top0_nxt = ex.push;
          top1_nxt = top0_r;
        end
        ACT_REPL: top0_nxt = ex.push;
        ACT_POP1: begin
          sp_nxt   = sp_r - SP_W'(1);
          top0_nxt = top1_r;
          top1_nxt = below0;
        end
        ACT_POP2PUSH: begin
          sp_nxt   = sp_r - SP_W'(1);
          top0_nxt = ex.push;
          top1_nxt = below0;
        end
        ACT_POP2: begin
          sp_nxt   = sp_r - SP_W'(2);
          top0_nxt = below0;
          top1_nxt = below1;
        end
        default: ;
      endcase
    end
  end

  // Write every pushed entry through to the RAM at its final slot
  assign wr_en   = in_fire && (ex.act == ACT_PUSH || ex.act == ACT_REPL ||
                               ex.act == ACT_POP2PUSH);
  assign wr_addr = ADDR_W'(sp_nxt - SP_W'(1));

  // Read ahead the two entries under the new top pair
  assign rd_addr0 = ADDR_W'(sp_nxt - SP_W'(3));
  assign rd_addr1 = ADDR_W'(sp_nxt - SP_W'(4));

  tsee_stack_ram u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (ex.push),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (below0),
    .rd_data1 (below1)
  );

  // Pack the result beat
  assign out_data_nxt = {2'b00, DEPTH_W'(sp_nxt), RETV_W'(ex.ret.value), ex.ret.tag,
                         ex.status};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold until the next accepted beat
  always_ff @(posedge clk) begin
    top0_r <= top0_nxt;
    top1_r <= top1_nxt;
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire
